// ===== rtl/core/modo_pkg.sv =====
package modo_pkg;

    localparam int WHEEL_COUNT = 4;

    // pi/2 in Q32
    localparam logic [32:0] HALF_PI_Q32 = 33'd6746518852;
    localparam logic [19:0] MICRO       = 20'd1000000;

    // configuration register indexes
    localparam logic [1:0] CFG_WHEEL_RADIUS  = 2'd0;
    localparam logic [1:0] CFG_AXLE_SUM      = 2'd1;
    localparam logic [1:0] CFG_TICKS_PER_REV = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ISSUE  = 6'b000010,
        S_MUL    = 6'b000100,
        S_DIV    = 6'b001000,
        S_TRIG   = 6'b010000,
        S_UNUSED = 6'b100000
    } state_t;

    // sequencer program, one entry per operation on a shared unit, then the final combine
    typedef enum logic [4:0] {
        OP_MR0, OP_P0, OP_MR1, OP_P1, OP_MR2, OP_P2, OP_NL,
        OP_BX, OP_BY, OP_DH,
        OP_NDT, OP_NLDT,
        OP_VX_NUM, OP_VX, OP_VY_NUM, OP_VY,
        OP_WZ_NUM1, OP_WZ_NUM2, OP_WZ,
        OP_TRIG,
        OP_XC, OP_YS, OP_XS, OP_YC,
        OP_FINAL
    } step_t;

    // arctangent of 2^-i as binary angle
    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/mecanum_odometry_core.sv =====
// Mecanum wheel odometry. Each request carries four wrapping encoder counts
// and a microsecond timestamp; the first request after reset only primes the
// stored counts and time and produces no result, every later one produces
// exactly one result: saturating x/y position in micrometres, wrapping 32-bit
// binary-angle heading, saturating body velocities (um/s, urad/s) and a flag
// for zero elapsed time (velocities then read zero). The body displacement is
// rotated by the heading held before the sample, using TRIG_ITERATIONS CORDIC
// steps. A small sequencer drives one bit-serial shift-add multiplier, one
// restoring divider (one quotient bit per cycle) and one CORDIC stage. The
// velocity steps are skipped when the elapsed time is zero. The divider
// forms 55-, 55-, 84- and 33-bit quotients; the multiplier takes one
// operand bit per cycle, stopping once the rest of that operand is zero.
// in_stall is high while a request is in work; a finished result waits in the
// output register and the next request can be taken meanwhile. Configuration
// writes (cfg_we, cfg_index, cfg_data) belong to idle time; a zero
// ticks_per_rev or axle_sum_um counts as one.
module mecanum_odometry_core #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [21:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] tick_fl,
    input  logic signed [31:0] tick_fr,
    input  logic signed [31:0] tick_rl,
    input  logic signed [31:0] tick_rr,
    input  logic [47:0]        timestamp_us,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [47:0] pos_x_um,
    output logic signed [47:0] pos_y_um,
    output logic [31:0]        heading,
    output logic signed [31:0] vel_x_ums,
    output logic signed [31:0] vel_y_ums,
    output logic signed [31:0] turn_rate_urads,
    output logic               zero_interval
);

    localparam int CI_W = $clog2(TRIG_ITERATIONS);
    localparam logic [CI_W-1:0] CI_LAST = CI_W'(TRIG_ITERATIONS - 1);
    // CORDIC start gain, with its small correction term
    localparam logic [33:0] X0 = (2 * TRIG_ITERATIONS < 31)
        ? 34'(652032874 + (434688583 >> (2 * TRIG_ITERATIONS)))
        : 34'd652032874;

    modo_pkg::state_t state_reg, state_next;
    modo_pkg::step_t  step_reg, step_next, step_inc;

    // configuration
    logic [19:0] r_reg;
    logic [21:0] l_reg;
    logic [15:0] n_reg;
    logic [21:0] l_eff;
    logic [15:0] n_eff;

    // architectural state
    logic        primed_reg;
    logic [31:0] cnt_reg [modo_pkg::WHEEL_COUNT];
    logic [47:0] time_reg;
    logic [47:0] acc_x_reg, acc_y_reg;
    logic [31:0] hd_reg;

    // per-request working values
    logic [33:0] ms_reg [3];
    logic [2:0]  sneg_reg;
    logic [47:0] dt_reg;
    logic        zero_reg;
    logic [53:0] mr_reg [3];
    logic [86:0] p_reg [3];
    logic [37:0] nl_reg;
    logic [63:0] ndt_reg;
    logic [85:0] nldt_reg;
    logic [127:0] num_reg;
    logic [54:0] bx_reg, by_reg;
    logic [31:0] dh_reg, vx_reg, vy_reg, wz_reg;
    logic signed [33:0] cos_reg, sin_reg;
    logic [57:0] pq_reg [4];

    // shared multiplier
    logic [127:0] ma_reg, macc_reg;
    logic [37:0]  mb_reg;
    // shared divider
    logic [127:0] drem_reg;
    logic [159:0] dd_reg;
    logic [83:0]  dq_reg;
    logic [6:0]   dcnt_reg;
    // CORDIC stage
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [32:0] cz_reg;
    logic [CI_W-1:0]    ci_reg;
    logic [1:0]         quad_reg;

    // output register
    logic        out_valid_reg;
    logic [47:0] o_x_reg, o_y_reg;
    logic [31:0] o_hd_reg, o_vx_reg, o_vy_reg, o_wz_reg;
    logic        o_zero_reg;

    logic accept, mul_done, div_last, trig_last, unit_done, fin_fire;
    logic is_mul, is_div;

    assign in_stall  = (state_reg != modo_pkg::S_IDLE);
    assign accept    = in_valid && (state_reg == modo_pkg::S_IDLE);
    assign mul_done  = (state_reg == modo_pkg::S_MUL) && (mb_reg == '0);
    assign div_last  = (state_reg == modo_pkg::S_DIV) && (dcnt_reg == '0);
    assign trig_last = (state_reg == modo_pkg::S_TRIG) && (ci_reg == CI_LAST);
    assign unit_done = mul_done || div_last || trig_last;
    assign fin_fire  = (state_reg == modo_pkg::S_ISSUE) && (step_reg == modo_pkg::OP_FINAL)
                       && !(out_valid_reg && out_stall);

    assign l_eff = (l_reg == '0) ? 22'd1 : l_reg;
    assign n_eff = (n_reg == '0) ? 16'd1 : n_reg;

    // skip the velocity program when no time went by
    assign step_inc = (step_reg == modo_pkg::OP_DH && zero_reg) ? modo_pkg::OP_TRIG
                      : modo_pkg::step_t'(step_reg + 5'd1);

    // ---------------- sample differences at request acceptance ----------------
    logic signed [34:0] d [4];
    logic signed [34:0] s0, s1, s2;
    logic [31:0] u [4];

    always_comb
    begin
        u[0] = tick_fl - cnt_reg[0];
        u[1] = tick_fr - cnt_reg[1];
        u[2] = tick_rl - cnt_reg[2];
        u[3] = tick_rr - cnt_reg[3];
        for (int i = 0; i < 4; i++)
        begin
            d[i] = 35'($signed(u[i]));
        end
        s0 = d[0] + d[1] + d[2] + d[3];
        s1 = -d[0] + d[1] + d[2] - d[3];
        s2 = -d[0] + d[1] - d[2] + d[3];
    end

    // ---------------- unit operand selection ----------------
    logic [127:0] mul_a;
    logic [37:0]  mul_b;
    logic [127:0] div_num, div_den;
    logic [159:0] dd_init;
    logic [6:0]   dk;
    logic [32:0]  cos_mag, sin_mag;

    assign cos_mag = cos_reg[33] ? 33'(-cos_reg) : cos_reg[32:0];
    assign sin_mag = sin_reg[33] ? 33'(-sin_reg) : sin_reg[32:0];

    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        div_num = '0;
        div_den = '0;
        is_mul  = 1'b0;
        is_div  = 1'b0;
        case (step_reg)
            modo_pkg::OP_MR0:     begin mul_a = 128'(ms_reg[0]); mul_b = 38'(r_reg); is_mul = 1'b1; end
            modo_pkg::OP_MR1:     begin mul_a = 128'(ms_reg[1]); mul_b = 38'(r_reg); is_mul = 1'b1; end
            modo_pkg::OP_MR2:     begin mul_a = 128'(ms_reg[2]); mul_b = 38'(r_reg); is_mul = 1'b1; end
            modo_pkg::OP_P0:
            begin
                mul_a = 128'(mr_reg[0]); mul_b = 38'(modo_pkg::HALF_PI_Q32); is_mul = 1'b1;
            end
            modo_pkg::OP_P1:
            begin
                mul_a = 128'(mr_reg[1]); mul_b = 38'(modo_pkg::HALF_PI_Q32); is_mul = 1'b1;
            end
            modo_pkg::OP_P2:
            begin
                mul_a = 128'(mr_reg[2]); mul_b = 38'(modo_pkg::HALF_PI_Q32); is_mul = 1'b1;
            end
            modo_pkg::OP_NL:      begin mul_a = 128'(l_eff); mul_b = 38'(n_eff); is_mul = 1'b1; end
            modo_pkg::OP_NDT:     begin mul_a = 128'(dt_reg); mul_b = 38'(n_eff); is_mul = 1'b1; end
            modo_pkg::OP_NLDT:    begin mul_a = 128'(dt_reg); mul_b = nl_reg; is_mul = 1'b1; end
            modo_pkg::OP_VX_NUM:
            begin
                mul_a = 128'(p_reg[0]); mul_b = 38'(modo_pkg::MICRO); is_mul = 1'b1;
            end
            modo_pkg::OP_VY_NUM:
            begin
                mul_a = 128'(p_reg[1]); mul_b = 38'(modo_pkg::MICRO); is_mul = 1'b1;
            end
            modo_pkg::OP_WZ_NUM1:
            begin
                mul_a = 128'(p_reg[2]); mul_b = 38'(modo_pkg::MICRO); is_mul = 1'b1;
            end
            modo_pkg::OP_WZ_NUM2:
            begin
                mul_a = num_reg; mul_b = 38'(modo_pkg::MICRO); is_mul = 1'b1;
            end
            modo_pkg::OP_XC:      begin mul_a = 128'(bx_reg); mul_b = 38'(cos_mag); is_mul = 1'b1; end
            modo_pkg::OP_YS:      begin mul_a = 128'(by_reg); mul_b = 38'(sin_mag); is_mul = 1'b1; end
            modo_pkg::OP_XS:      begin mul_a = 128'(bx_reg); mul_b = 38'(sin_mag); is_mul = 1'b1; end
            modo_pkg::OP_YC:      begin mul_a = 128'(by_reg); mul_b = 38'(cos_mag); is_mul = 1'b1; end
            modo_pkg::OP_BX:
            begin
                div_num = 128'(p_reg[0]); div_den = 128'(n_eff) << 32; is_div = 1'b1;
            end
            modo_pkg::OP_BY:
            begin
                div_num = 128'(p_reg[1]); div_den = 128'(n_eff) << 32; is_div = 1'b1;
            end
            modo_pkg::OP_DH:
            begin
                div_num = 128'(mr_reg[2]) << 30; div_den = 128'(nl_reg); is_div = 1'b1;
            end
            modo_pkg::OP_VX:
            begin
                div_num = num_reg; div_den = 128'(ndt_reg) << 32; is_div = 1'b1;
            end
            modo_pkg::OP_VY:
            begin
                div_num = num_reg; div_den = 128'(ndt_reg) << 32; is_div = 1'b1;
            end
            modo_pkg::OP_WZ:
            begin
                div_num = num_reg; div_den = 128'(nldt_reg) << 32; is_div = 1'b1;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // top quotient bit of each division
    always_comb
    begin
        case (step_reg) inside
            modo_pkg::OP_BX, modo_pkg::OP_BY:
            begin
                dk      = 7'd54;
                dd_init = {32'd0, div_den} << 54;
            end
            modo_pkg::OP_DH:
            begin
                dk      = 7'd83;
                dd_init = {32'd0, div_den} << 83;
            end
            default:
            begin
                dk      = 7'd32;
                dd_init = {32'd0, div_den} << 32;
            end
        endcase
    end

    // ---------------- unit step logic ----------------
    logic         div_ge;
    logic [83:0]  q_new;
    logic [87:0]  pq_round;

    assign div_ge   = ({32'd0, drem_reg} >= dd_reg);
    assign q_new    = {dq_reg[82:0], div_ge};
    assign pq_round = macc_reg[87:0] + 88'd536870912;

    function automatic logic [31:0] vel_sat(input logic [32:0] q, input logic neg);
        logic [31:0] lim;
        logic [31:0] m;
        lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        m   = (q[32] || (q[31:0] > lim)) ? lim : q[31:0];
        return neg ? -m : m;
    endfunction

    // CORDIC start and step
    logic [31:0] hd_bias, ru;
    logic [1:0]  qd;
    logic signed [33:0] xs, ys, x_n, y_n;
    logic signed [32:0] z_n, at_s;

    always_comb
    begin
        hd_bias = hd_reg + 32'h2000_0000;
        qd      = hd_bias[31:30];
        ru      = hd_reg - {qd, 30'd0};
        xs      = cx_reg >>> ci_reg;
        ys      = cy_reg >>> ci_reg;
        at_s    = $signed({1'b0, modo_pkg::atan_entry(5'(ci_reg))});
        if (!cz_reg[32])
        begin
            x_n = cx_reg - ys;
            y_n = cy_reg + xs;
            z_n = cz_reg - at_s;
        end
        else
        begin
            x_n = cx_reg + ys;
            y_n = cy_reg - xs;
            z_n = cz_reg + at_s;
        end
    end

    // ---------------- final combine ----------------
    logic signed [61:0] t_xc, t_ys, t_xs, t_yc, nx, ny;
    logic [47:0] sat_x, sat_y;

    always_comb
    begin
        t_xc = $signed({4'd0, pq_reg[0]});
        t_ys = $signed({4'd0, pq_reg[1]});
        t_xs = $signed({4'd0, pq_reg[2]});
        t_yc = $signed({4'd0, pq_reg[3]});
        if (sneg_reg[0] ^ cos_reg[33]) t_xc = -t_xc;
        if (sneg_reg[1] ^ sin_reg[33]) t_ys = -t_ys;
        if (sneg_reg[0] ^ sin_reg[33]) t_xs = -t_xs;
        if (sneg_reg[1] ^ cos_reg[33]) t_yc = -t_yc;
        nx = 62'($signed(acc_x_reg)) + t_xc - t_ys;
        ny = 62'($signed(acc_y_reg)) + t_xs + t_yc;
        // clamp to the 48-bit signed range
        if (nx[61:47] != {15{nx[61]}})
            sat_x = nx[61] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
        else
            sat_x = nx[47:0];
        if (ny[61:47] != {15{ny[61]}})
            sat_y = ny[61] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
        else
            sat_y = ny[47:0];
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg) inside
            modo_pkg::S_IDLE:
            begin
                if (accept && primed_reg)
                begin
                    state_next = modo_pkg::S_ISSUE;
                    step_next  = modo_pkg::OP_MR0;
                end
            end
            modo_pkg::S_ISSUE:
            begin
                if (is_mul)
                    state_next = modo_pkg::S_MUL;
                else if (is_div)
                    state_next = modo_pkg::S_DIV;
                else if (step_reg == modo_pkg::OP_TRIG)
                    state_next = modo_pkg::S_TRIG;
                else if (fin_fire)
                    state_next = modo_pkg::S_IDLE;
            end
            modo_pkg::S_MUL, modo_pkg::S_DIV, modo_pkg::S_TRIG:
            begin
                if (unit_done)
                begin
                    state_next = modo_pkg::S_ISSUE;
                    step_next  = step_inc;
                end
            end
            default:
            begin
                state_next = modo_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= modo_pkg::S_IDLE;
            step_reg      <= modo_pkg::OP_MR0;
            r_reg         <= 20'd50000;
            l_reg         <= 22'd350000;
            n_reg         <= 16'd500;
            primed_reg    <= 1'b0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            hd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    modo_pkg::CFG_WHEEL_RADIUS:  r_reg <= cfg_data[19:0];
                    modo_pkg::CFG_AXLE_SUM:      l_reg <= cfg_data;
                    modo_pkg::CFG_TICKS_PER_REV: n_reg <= cfg_data[15:0];
                    default:                     r_reg <= r_reg;
                endcase
            end
            if (accept)
                primed_reg <= 1'b1;
            // post a new result, or drop the old one once taken
            if (fin_fire)
            begin
                out_valid_reg <= 1'b1;
                acc_x_reg     <= sat_x;
                acc_y_reg     <= sat_y;
                hd_reg        <= hd_reg + dh_reg;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cnt_reg[0] <= tick_fl;
            cnt_reg[1] <= tick_fr;
            cnt_reg[2] <= tick_rl;
            cnt_reg[3] <= tick_rr;
            time_reg   <= timestamp_us;
            dt_reg     <= timestamp_us - time_reg;
            zero_reg   <= (timestamp_us == time_reg);
            ms_reg[0]  <= s0[34] ? 34'(-s0) : s0[33:0];
            ms_reg[1]  <= s1[34] ? 34'(-s1) : s1[33:0];
            ms_reg[2]  <= s2[34] ? 34'(-s2) : s2[33:0];
            sneg_reg   <= {s2[34], s1[34], s0[34]};
        end

        // load all units at issue; only the one selected runs
        if (state_reg == modo_pkg::S_ISSUE)
        begin
            ma_reg   <= mul_a;
            mb_reg   <= mul_b;
            macc_reg <= '0;
            drem_reg <= div_num + (div_den >> 1);
            dd_reg   <= dd_init;
            dq_reg   <= '0;
            dcnt_reg <= dk;
            cx_reg   <= $signed(X0);
            cy_reg   <= '0;
            cz_reg   <= $signed({ru[31], ru});
            ci_reg   <= '0;
            quad_reg <= qd;
        end

        if (state_reg == modo_pkg::S_MUL)
        begin
            if (mb_reg != '0)
            begin
                if (mb_reg[0])
                    macc_reg <= macc_reg + ma_reg;
                ma_reg <= ma_reg << 1;
                mb_reg <= mb_reg >> 1;
            end
            else
            begin
                case (step_reg)
                    modo_pkg::OP_MR0:    mr_reg[0] <= macc_reg[53:0];
                    modo_pkg::OP_MR1:    mr_reg[1] <= macc_reg[53:0];
                    modo_pkg::OP_MR2:    mr_reg[2] <= macc_reg[53:0];
                    modo_pkg::OP_P0:     p_reg[0]  <= macc_reg[86:0];
                    modo_pkg::OP_P1:     p_reg[1]  <= macc_reg[86:0];
                    modo_pkg::OP_P2:     p_reg[2]  <= macc_reg[86:0];
                    modo_pkg::OP_NL:     nl_reg    <= macc_reg[37:0];
                    modo_pkg::OP_NDT:    ndt_reg   <= macc_reg[63:0];
                    modo_pkg::OP_NLDT:   nldt_reg  <= macc_reg[85:0];
                    modo_pkg::OP_XC:     pq_reg[0] <= pq_round[87:30];
                    modo_pkg::OP_YS:     pq_reg[1] <= pq_round[87:30];
                    modo_pkg::OP_XS:     pq_reg[2] <= pq_round[87:30];
                    modo_pkg::OP_YC:     pq_reg[3] <= pq_round[87:30];
                    default:             num_reg   <= macc_reg;
                endcase
            end
        end

        if (state_reg == modo_pkg::S_DIV)
        begin
            if (div_ge)
                drem_reg <= drem_reg - dd_reg[127:0];
            dq_reg   <= q_new;
            dd_reg   <= dd_reg >> 1;
            dcnt_reg <= dcnt_reg - 7'd1;
            if (dcnt_reg == '0)
            begin
                case (step_reg)
                    modo_pkg::OP_BX: bx_reg <= q_new[54:0];
                    modo_pkg::OP_BY: by_reg <= q_new[54:0];
                    modo_pkg::OP_DH: dh_reg <= sneg_reg[2] ? -q_new[31:0] : q_new[31:0];
                    modo_pkg::OP_VX: vx_reg <= vel_sat(q_new[32:0], sneg_reg[0]);
                    modo_pkg::OP_VY: vy_reg <= vel_sat(q_new[32:0], sneg_reg[1]);
                    default:         wz_reg <= vel_sat(q_new[32:0], sneg_reg[2]);
                endcase
            end
        end

        if (state_reg == modo_pkg::S_TRIG)
        begin
            cx_reg <= x_n;
            cy_reg <= y_n;
            cz_reg <= z_n;
            ci_reg <= ci_reg + CI_W'(1);
            if (ci_reg == CI_LAST)
            begin
                // map the folded result back to its quadrant
                case (quad_reg)
                    2'd0:    begin cos_reg <= x_n;  sin_reg <= y_n;  end
                    2'd1:    begin cos_reg <= -y_n; sin_reg <= x_n;  end
                    2'd2:    begin cos_reg <= -x_n; sin_reg <= -y_n; end
                    default: begin cos_reg <= y_n;  sin_reg <= -x_n; end
                endcase
            end
        end

        if (fin_fire)
        begin
            o_x_reg    <= sat_x;
            o_y_reg    <= sat_y;
            o_hd_reg   <= hd_reg + dh_reg;
            o_vx_reg   <= zero_reg ? 32'd0 : vx_reg;
            o_vy_reg   <= zero_reg ? 32'd0 : vy_reg;
            o_wz_reg   <= zero_reg ? 32'd0 : wz_reg;
            o_zero_reg <= zero_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign pos_x_um        = o_x_reg;
    assign pos_y_um        = o_y_reg;
    assign heading         = o_hd_reg;
    assign vel_x_ums       = o_vx_reg;
    assign vel_y_ums       = o_vy_reg;
    assign turn_rate_urads = o_wz_reg;
    assign zero_interval   = o_zero_reg;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

    // run limit in cycles, with room for the slowest item plus stalls
    localparam int unsigned CYCLE_LIMIT = 8000000;
    // quiet time before a register write or the final verdict
    localparam int          SETTLE_CYCLES = 3000;

    typedef struct {
        logic [47:0] pos_x;
        logic [47:0] pos_y;
        logic [31:0] hdg;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] wz;
        logic        zflag;
    } pose_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [21:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] tick_fl;
    logic signed [31:0] tick_fr;
    logic signed [31:0] tick_rl;
    logic signed [31:0] tick_rr;
    logic [47:0]        timestamp_us;
    logic               out_valid;
    logic               out_stall;
    logic signed [47:0] pos_x_um;
    logic signed [47:0] pos_y_um;
    logic [31:0]        heading;
    logic signed [31:0] vel_x_ums;
    logic signed [31:0] vel_y_ums;
    logic signed [31:0] turn_rate_urads;
    logic               zero_interval;

    mecanum_odometry_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .tick_fl         (tick_fl),
        .tick_fr         (tick_fr),
        .tick_rl         (tick_rl),
        .tick_rr         (tick_rr),
        .timestamp_us    (timestamp_us),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .pos_x_um        (pos_x_um),
        .pos_y_um        (pos_y_um),
        .heading         (heading),
        .vel_x_ums       (vel_x_ums),
        .vel_y_ums       (vel_y_ums),
        .turn_rate_urads (turn_rate_urads),
        .zero_interval   (zero_interval)
    );

    // shadow of the block: geometry registers and odometry state
    logic [19:0] wheel_r;
    logic [21:0] axle_l;
    logic [15:0] tpr;
    logic        primed;
    logic [31:0] prev_cnt [4];
    logic [47:0] prev_ts;
    longint      odo_x;
    longint      odo_y;
    logic [31:0] odo_hdg;

    pose_t       pose_q[$];
    int          errors;
    int unsigned cycles;
    // when set, neither side inserts idle cycles
    bit          steady;

    // binary-angle arctangent of 2^-i for the rotation steps
    logic [31:0] atan_lut [16] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861
    };

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // hard stop on a hung pipeline
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver stalls in about one cycle out of ten unless steady is set
    always @(negedge clk)
    begin
        out_stall <= !steady && ($urandom_range(0, 99) < 10);
    end

    function automatic logic [63:0] magnitude(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint apply_sign(logic [63:0] m, bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // divide magnitudes, rounding to nearest with ties away from zero
    function automatic logic [127:0] round_div(logic [127:0] num, logic [127:0] den);
        return (num + (den >> 1)) / den;
    endfunction

    function automatic longint clamp_rate(logic [127:0] q, bit neg);
        logic [127:0] lim;
        lim = neg ? 128'd2147483648 : 128'd2147483647;
        return apply_sign(q > lim ? lim[63:0] : q[63:0], neg);
    endfunction

    // product with a Q30 trig value, rounded
    function automatic longint scale_q30(longint v, longint c);
        logic [127:0] p;
        p = 128'(magnitude(v)) * 128'(magnitude(c)) + (128'd1 << 29);
        return apply_sign(p[93:30], (v < 0) != (c < 0));
    endfunction

    function automatic longint clamp_pos(longint a, longint d);
        longint s;
        s = a + d;
        if (s > 64'sd140737488355327)
            return 64'sd140737488355327;
        if (s < -64'sd140737488355328)
            return -64'sd140737488355328;
        return s;
    endfunction

    task automatic heading_trig(input logic [31:0] h, output longint c, output longint s);
        logic [31:0] quad;
        logic [31:0] ru;
        longint      x;
        longint      y;
        longint      z;
        longint      xs;
        longint      ys;
        quad = ((h + 32'h2000_0000) >> 30) & 32'd3;
        ru = h - (quad << 30);
        z = longint'($signed(ru));
        // gain term vanishes at sixteen steps
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(atan_lut[i]);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(atan_lut[i]);
            end
        end
        case (quad)
            32'd0:   begin c = x;  s = y;  end
            32'd1:   begin c = -y; s = x;  end
            32'd2:   begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
    endtask

    // advance the shadow state by one accepted sample; queue the pose it yields
    task automatic track_sample(input logic [31:0] cnt [4], input logic [47:0] ts);
        longint       d [4];
        logic [31:0]  u;
        logic [47:0]  dt;
        logic [63:0]  n;
        logic [63:0]  l;
        logic [63:0]  nl;
        longint       s0;
        longint       s1;
        longint       s2;
        logic [127:0] p0;
        logic [127:0] p1;
        logic [127:0] p2;
        logic [127:0] dn;
        logic [127:0] dv;
        logic [127:0] dw;
        logic [127:0] q;
        longint       bx;
        longint       by;
        longint       c;
        longint       s;
        logic [31:0]  dh;
        pose_t        e;
        if (!primed)
        begin
            for (int i = 0; i < 4; i++)
                prev_cnt[i] = cnt[i];
            prev_ts = ts;
            primed = 1'b1;
            return;
        end
        for (int i = 0; i < 4; i++)
        begin
            u = cnt[i] - prev_cnt[i];
            d[i] = longint'($signed(u));
            prev_cnt[i] = cnt[i];
        end
        dt = ts - prev_ts;
        prev_ts = ts;
        n = (tpr == 0) ? 64'd1 : 64'(tpr);
        l = (axle_l == 0) ? 64'd1 : 64'(axle_l);
        nl = n * l;
        s0 = d[0] + d[1] + d[2] + d[3];
        s1 = -d[0] + d[1] + d[2] - d[3];
        s2 = -d[0] + d[1] - d[2] + d[3];
        p0 = 128'(magnitude(s0) * 64'(wheel_r)) * 128'(modo_pkg::HALF_PI_Q32);
        p1 = 128'(magnitude(s1) * 64'(wheel_r)) * 128'(modo_pkg::HALF_PI_Q32);
        p2 = 128'(magnitude(s2) * 64'(wheel_r)) * 128'(modo_pkg::HALF_PI_Q32);
        dn = 128'(n) << 32;
        bx = apply_sign(64'(round_div(p0, dn)), s0 < 0);
        by = apply_sign(64'(round_div(p1, dn)), s1 < 0);
        q = round_div(128'(magnitude(s2) * 64'(wheel_r)) << 30, 128'(nl));
        dh = (s2 < 0) ? -q[31:0] : q[31:0];
        e.zflag = (dt == 0);
        e.vx = '0;
        e.vy = '0;
        e.wz = '0;
        if (dt != 0)
        begin
            dv = (128'(n) * 128'(dt)) << 32;
            dw = (128'(nl) * 128'(dt)) << 32;
            e.vx = 32'(clamp_rate(round_div(p0 * 128'd1000000, dv), s0 < 0));
            e.vy = 32'(clamp_rate(round_div(p1 * 128'd1000000, dv), s1 < 0));
            e.wz = 32'(clamp_rate(round_div(p2 * 128'd1000000 * 128'd1000000, dw),
                                  s2 < 0));
        end
        heading_trig(odo_hdg, c, s);
        odo_x = clamp_pos(odo_x, scale_q30(bx, c) - scale_q30(by, s));
        odo_y = clamp_pos(odo_y, scale_q30(bx, s) + scale_q30(by, c));
        odo_hdg = odo_hdg + dh;
        e.pos_x = odo_x[47:0];
        e.pos_y = odo_y[47:0];
        e.hdg = odo_hdg;
        pose_q.push_back(e);
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("tb: mismatch %s got %h want %h at cycle %0d", what, got, want, cycles);
    endtask

    // compare each accepted result with the oldest predicted pose
    always @(posedge clk)
    begin
        pose_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pose_q.size() == 0)
                report("unexpected result", 64'(pos_x_um), 64'd0);
            else
            begin
                e = pose_q.pop_front();
                if (pos_x_um !== e.pos_x)       report("pos_x_um", 64'(pos_x_um), 64'(e.pos_x));
                if (pos_y_um !== e.pos_y)       report("pos_y_um", 64'(pos_y_um), 64'(e.pos_y));
                if (heading !== e.hdg)          report("heading", 64'(heading), 64'(e.hdg));
                if (vel_x_ums !== e.vx)         report("vel_x_ums", 64'(vel_x_ums), 64'(e.vx));
                if (vel_y_ums !== e.vy)         report("vel_y_ums", 64'(vel_y_ums), 64'(e.vy));
                if (turn_rate_urads !== e.wz)
                    report("turn_rate_urads", 64'(turn_rate_urads), 64'(e.wz));
                if (zero_interval !== e.zflag)
                    report("zero_interval", 64'(zero_interval), 64'(e.zflag));
            end
        end
    end

    // offer one sample request and hold it until taken
    task automatic send_sample(input logic [31:0] fl, input logic [31:0] fr,
                               input logic [31:0] rl, input logic [31:0] rr,
                               input logic [47:0] ts);
        logic [31:0] cnt [4];
        if (!steady && $urandom_range(0, 99) < 10)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(0, 30)) @(negedge clk);
        end
        @(negedge clk);
        tick_fl = fl;
        tick_fr = fr;
        tick_rl = rl;
        tick_rr = rr;
        timestamp_us = ts;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        cnt = '{fl, fr, rl, rr};
        track_sample(cnt, ts);
    endtask

    // step each wheel from its last count and the clock from its last stamp
    task automatic send_delta(input int dfl, input int dfr, input int drl, input int drr,
                              input logic [47:0] dt);
        send_sample(prev_cnt[0] + dfl, prev_cnt[1] + dfr, prev_cnt[2] + drl,
                    prev_cnt[3] + drr, prev_ts + dt);
    endtask

    // drain all results, then let any priming request finish
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pose_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [21:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            modo_pkg::CFG_WHEEL_RADIUS:  wheel_r = val[19:0];
            modo_pkg::CFG_AXLE_SUM:      axle_l = val;
            modo_pkg::CFG_TICKS_PER_REV: tpr = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [21:0] r, input logic [21:0] l,
                                input logic [21:0] n);
        wait_idle();
        write_reg(modo_pkg::CFG_WHEEL_RADIUS, r);
        write_reg(modo_pkg::CFG_AXLE_SUM, l);
        write_reg(modo_pkg::CFG_TICKS_PER_REV, n);
    endtask

    // priming, wraps, zero interval, quadrant sweep and extreme steps
    task automatic test_directed();
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFF0);
        // clock wraps through zero
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 48'h0);
        // same stamp: zero interval but the pose still moves
        send_delta(100, 100, 100, 100, 48'd0);
        send_delta(1000, 1000, 1000, 1000, 48'd1000);
        send_delta(-500, 500, 500, -500, 48'd2000);
        // eighth turns walk the heading through every quadrant
        for (int k = 0; k < 9; k++)
            send_delta(-437 + 200, 437 + 200, -437 + 200, 437 + 200, 48'd10000);
        // largest single steps saturate the rates
        send_delta(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 48'd1);
        send_delta(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 48'd1);
        send_delta(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 48'd1);
        send_delta(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 48'd1);
        send_delta(0, 0, 0, 0, 48'hFFFF_FFFF_FFFF);
        send_delta(-1, -1, -1, -1, 48'h8000_0000_0000);
    endtask

    task automatic random_item();
        int unsigned mode;
        int          span;
        mode = $urandom_range(0, 99);
        if (mode < 80)
        begin
            span = $urandom_range(0, 3) == 0 ? 20000 : 1500;
            send_delta($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
                       $urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
                       $urandom_range(0, 19) == 0 ? 48'd0 : 48'($urandom_range(1, 100000)));
        end
        else if (mode < 90)
            send_delta($urandom, $urandom, $urandom, $urandom,
                       {16'($urandom_range(0, 3)), 32'($urandom)});
        else
            send_sample($urandom, $urandom, $urandom, $urandom, {16'($urandom), 32'($urandom)});
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            steady = (i >= count / 3) && (i < count / 2);
            random_item();
        end
        steady = 1'b0;
    endtask

    // extreme and zero geometry, sampled with random motion
    task automatic test_geometry();
        set_geometry(22'd1000, 22'd1000, 22'd1);
        test_random(120);
        set_geometry(22'hFFFFF, 22'h3FFFFF, 22'hFFFF);
        test_random(120);
        // zero ticks and zero axle both count as one
        set_geometry(22'hFFFFF, 22'd0, 22'd0);
        test_random(120);
        set_geometry(22'd0, 22'd4000000, 22'd65535);
        test_random(60);
        set_geometry(22'd1000000, 22'd1000, 22'd1);
        test_random(120);
        set_geometry(22'($urandom_range(1000, 1000000)), 22'($urandom_range(1000, 4000000)),
                     22'($urandom_range(1, 65535)));
        test_random(200);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = modo_pkg::CFG_WHEEL_RADIUS;
        cfg_data = '0;
        in_valid = 1'b0;
        tick_fl = '0;
        tick_fr = '0;
        tick_rl = '0;
        tick_rr = '0;
        timestamp_us = '0;
        out_stall = 1'b0;
        errors = 0;
        cycles = 0;
        steady = 1'b0;
        wheel_r = 20'd50000;
        axle_l = 22'd350000;
        tpr = 16'd500;
        primed = 1'b0;
        for (int i = 0; i < 4; i++)
            prev_cnt[i] = '0;
        prev_ts = '0;
        odo_x = 0;
        odo_y = 0;
        odo_hdg = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(400);
        test_geometry();
        set_geometry(22'd50000, 22'd350000, 22'd500);
        test_random(100);

        wait_idle();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
